>>> rtl/core/mnf_pkg.sv
// mnf_pkg: shared types and constants of the 3x3 neighbour mean filter
// no dependencies; imported by mnf_front, mnf_back and the top level
package mnf_pkg;

  localparam int CFG_W = 11;
  localparam int unsigned RESET_DIM = 5;
  localparam int OUT_POS_W = 10;
  localparam int NEIGH_SHIFT = 3;
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic MODE_PIX = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    OP_PIX,
    OP_DRAIN,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic res0;
    logic res1;
    logic b0;
    logic top;
    logic bot;
    logic left0;
    logic right0;
    logic left1;
    logic fend;
  } cmd_flags_t;

endpackage

>>> rtl/core/mnf_ram.sv
// mnf_ram: generic single write, single read ram with registered read data
// no dependencies
module mnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mnf_fifo.sv
// mnf_fifo: small register fifo with occupancy count, depth a power of two
// depends on nothing; used for the command queue and the result queue
module mnf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNW-1:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNW'(DEPTH));
  assign count   = cnt_r;
  assign dout    = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_r + CNW'(do_push) - CNW'(do_pop);
    end
  end

endmodule

>>> rtl/core/mnf_front.sv
// mnf_front: frame size registers, raster position tracking and drain bookkeeping
// depends on mnf_pkg; pixel words and pending drain words become mnf_back commands
module mnf_front import mnf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata,
  input  logic                          push,
  input  logic                          in_mode,
  input  logic [PIXEL_BITS-1:0]         in_pixel,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output cmd_flags_t                    cmd_flags,
  output logic [PIXEL_BITS-1:0]         cmd_px,
  output logic [$clog2(MAX_WIDTH)-1:0]  cmd_addr,
  output logic [$clog2(MAX_HEIGHT)-1:0] cmd_row,
  output logic [$clog2(MAX_WIDTH)-1:0]  cmd_col
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW = $clog2(MAXD + 1);

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v, input int unsigned lim);
    logic [DW-1:0] d;
    if (v == '0) begin
      d = DW'(1);
    end else if (32'(v) > lim) begin
      d = DW'(lim);
    end else begin
      d = DW'(v);
    end
    return d;
  endfunction

  logic [DW-1:0] eff_w_r;
  logic [DW-1:0] eff_h_r;
  logic [RW-1:0] in_row_r;
  logic [CW-1:0] in_col_r;
  logic [RW-1:0] emit_row_r;
  logic [CW-1:0] emit_col_r;
  logic          pend_r;

  logic          accept;
  logic [DW-1:0] col_inc;
  logic [DW-1:0] row_inc;
  logic [DW-1:0] em_inc;
  logic          col_last;
  logic          row_last;
  logic          em_right;
  logic          has_row;
  logic          res_a;
  logic          res_b;

  always_comb begin
    accept   = push && !cmd_full;
    col_inc  = DW'(in_col_r) + DW'(1);
    row_inc  = DW'(in_row_r) + DW'(1);
    em_inc   = DW'(emit_col_r) + DW'(1);
    col_last = (col_inc == eff_w_r);
    row_last = (row_inc == eff_h_r);
    em_right = (em_inc < eff_w_r);
    has_row  = (in_row_r != '0);
    res_a    = has_row && (in_col_r != '0);
    res_b    = has_row && col_last;

    cmd_flags = '0;
    cmd_px    = in_pixel;
    if (in_mode == MODE_DRAIN) begin
      cmd_flags.op     = OP_DRAIN;
      cmd_flags.res0   = 1'b1;
      cmd_flags.top    = (emit_row_r != '0);
      cmd_flags.left0  = (emit_col_r != '0);
      cmd_flags.right0 = em_right;
      cmd_flags.fend   = !em_right;
      cmd_addr         = CW'(em_inc);
      cmd_row          = emit_row_r;
      cmd_col          = emit_col_r;
    end else begin
      cmd_flags.op     = OP_PIX;
      cmd_flags.res0   = res_a || res_b;
      cmd_flags.res1   = res_a && res_b;
      cmd_flags.b0     = !res_a;
      cmd_flags.top    = (in_row_r >= RW'(2));
      cmd_flags.bot    = 1'b1;
      cmd_flags.left0  = res_a ? (in_col_r >= CW'(2)) : (in_col_r != '0);
      cmd_flags.right0 = res_a;
      cmd_flags.left1  = (in_col_r != '0);
      cmd_addr         = in_col_r;
      cmd_row          = in_row_r - RW'(1);
      cmd_col          = res_a ? (in_col_r - CW'(1)) : in_col_r;
    end
    cmd_push = accept && ((in_mode == MODE_PIX) || pend_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r    <= eff_dim(CFG_W'(RESET_DIM), MAX_WIDTH);
      eff_h_r    <= eff_dim(CFG_W'(RESET_DIM), MAX_HEIGHT);
      in_row_r   <= '0;
      in_col_r   <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
      pend_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          eff_w_r <= eff_dim(cfg_wdata, MAX_WIDTH);
        end
        REG_FRAME_HEIGHT: begin
          eff_h_r <= eff_dim(cfg_wdata, MAX_HEIGHT);
        end
        default: begin
        end
      endcase
      in_row_r   <= '0;
      in_col_r   <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
      pend_r     <= 1'b0;
    end else if (accept) begin
      if (in_mode == MODE_DRAIN) begin
        if (pend_r) begin
          if (em_right) begin
            emit_col_r <= emit_col_r + CW'(1);
          end else begin
            pend_r     <= 1'b0;
            emit_row_r <= '0;
            emit_col_r <= '0;
          end
        end
      end else begin
        pend_r <= 1'b0;
        if (col_last) begin
          in_col_r <= '0;
          if (row_last) begin
            in_row_r   <= '0;
            pend_r     <= 1'b1;
            emit_row_r <= RW'(eff_h_r - DW'(1));
            emit_col_r <= '0;
          end else begin
            in_row_r <= in_row_r + RW'(1);
          end
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
    end
  end

endmodule

>>> rtl/core/mnf_back.sv
// mnf_back: line store access, 3x3 window and neighbour sums
// depends on mnf_pkg and mnf_ram; takes commands from the queue, pushes result words
module mnf_back import mnf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_empty,
  input  cmd_flags_t                     cmd_flags,
  input  logic [PIXEL_BITS-1:0]          cmd_px,
  input  logic [$clog2(MAX_WIDTH)-1:0]   cmd_addr,
  input  logic [$clog2(MAX_HEIGHT)-1:0]  cmd_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]   cmd_col,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           out_push,
  output logic [2*(PIXEL_BITS+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH)+2):0] out_entry
);

  localparam int PB = PIXEL_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = PB + NEIGH_SHIFT;
  localparam int SLW = PB + RW + CW + 2;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  typedef logic [2:0][2:0][PB-1:0] win_t;

  function automatic logic [PB-1:0] nsum(input win_t a, input logic top, input logic bot,
                                         input logic left, input logic right);
    logic [SW-1:0] s;
    logic          take;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        take = !(i == 1 && j == 1) && !(i == 0 && !top) && !(i == 2 && !bot) &&
               !(j == 0 && !left) && !(j == 2 && !right);
        if (take) begin
          s = s + SW'(a[i][j]);
        end
      end
    end
    return s[SW-1:NEIGH_SHIFT];
  endfunction

  // issue
  logic          loaded_r;
  logic [OCW:0]  occ;
  logic          issue;
  logic          do_load;
  logic [CW-1:0] iss_addr;
  cmd_flags_t    iss_flags;

  // window stage
  logic            s2_v_r;
  cmd_flags_t      s2_flags_r;
  logic [PB-1:0]   s2_px_r;
  logic [CW-1:0]   s2_addr_r;
  logic [RW-1:0]   s2_row_r;
  logic [CW-1:0]   s2_col_r;
  logic            fwd_hit_r;
  logic [2*PB-1:0] fwd_r;
  logic [2*PB-1:0] ram_rdata;
  logic [2*PB-1:0] rd_word;
  logic [PB-1:0]   rd_prev2;
  logic [PB-1:0]   rd_prev;
  logic            ram_we;
  win_t            win_r;
  win_t            win_nxt;

  // sum stage
  logic          s3_v_r;
  cmd_flags_t    s3_flags_r;
  logic [RW-1:0] s3_row_r;
  logic [CW-1:0] s3_col_r;
  win_t          sh;
  win_t          arr0;
  logic [PB-1:0] sum0;
  logic [PB-1:0] sum1;
  logic [SLW-1:0] slot0;
  logic [SLW-1:0] slot1;

  always_comb begin
    occ     = (OCW+1)'(out_count) + (OCW+1)'(s2_v_r) + (OCW+1)'(s3_v_r);
    issue   = !cmd_empty && (occ < (OCW+1)'(OUT_DEPTH));
    // first drain word of a frame primes column zero into the window
    do_load = (cmd_flags.op == OP_DRAIN) && (cmd_col == '0) && !loaded_r;
    cmd_pop = issue && !do_load;
    iss_addr  = do_load ? '0 : cmd_addr;
    iss_flags = cmd_flags;
    if (do_load) begin
      iss_flags    = '0;
      iss_flags.op = OP_LOAD;
    end
  end

  always_comb begin
    rd_word  = fwd_hit_r ? fwd_r : ram_rdata;
    rd_prev2 = rd_word[2*PB-1:PB];
    rd_prev  = rd_word[PB-1:0];
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = rd_prev2;
    win_nxt[1][2] = rd_prev;
    win_nxt[2][2] = s2_px_r;
    ram_we = s2_v_r && (s2_flags_r.op == OP_PIX);
  end

  mnf_ram #(
    .WIDTH(2 * PB),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s2_addr_r),
    .wdata({rd_prev, s2_px_r}),
    .raddr(iss_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (issue) begin
        loaded_r <= do_load;
      end
      s2_v_r    <= issue;
      s3_v_r    <= s2_v_r;
      fwd_hit_r <= issue && ram_we && (iss_addr == s2_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    s2_flags_r <= iss_flags;
    s2_px_r    <= cmd_px;
    s2_addr_r  <= iss_addr;
    s2_row_r   <= cmd_row;
    s2_col_r   <= cmd_col;
    fwd_r      <= {rd_prev, s2_px_r};
    if (s2_v_r) begin
      win_r <= win_nxt;
    end
    s3_flags_r <= s2_flags_r;
    s3_row_r   <= s2_row_r;
    s3_col_r   <= s2_col_r;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i][0] = win_r[i][1];
      sh[i][1] = win_r[i][2];
      sh[i][2] = '0;
    end
    arr0 = s3_flags_r.b0 ? sh : win_r;
    sum0 = nsum(arr0, s3_flags_r.top, s3_flags_r.bot, s3_flags_r.left0, s3_flags_r.right0);
    sum1 = nsum(sh, s3_flags_r.top, s3_flags_r.bot, s3_flags_r.left1, 1'b0);
    slot0 = {sum0, s3_row_r, s3_col_r, s3_flags_r.fend, !s3_flags_r.res1};
    slot1 = {sum1, s3_row_r, s3_col_r + CW'(1), 1'b0, 1'b1};
    out_entry = {s3_flags_r.res1, slot1, slot0};
    out_push  = s3_v_r && s3_flags_r.res0;
  end

endmodule

>>> rtl/core/neighbour_mean_filter_3x3_top.sv
// neighbour_mean_filter_3x3_top: streaming 3x3 neighbour mean, top level
// depends on mnf_pkg, mnf_front, mnf_fifo and mnf_back
//
// Takes one word per clock while full is low, pixel or drain, in raster order and gives for
// every pixel the sum of its in-frame neighbours (centre left out) divided by eight. A result
// comes out once the pixel below and to its right has arrived, or at the end of the next row;
// the last row is flushed by drain words, one result each. Sustained rate is one word per
// clock while results are popped as they come; a pixel at the end of a row gives two results,
// which take two pops. The first drain word of a frame waits while the single read port of
// the line store loads column zero. The line store needs no clearing after reset. Writing a
// frame size register restarts the frame.
module neighbour_mean_filter_3x3_top import mnf_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_mode,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  empty,
  input  logic                  pop,
  output logic [PIXEL_BITS-1:0] out_filtered,
  output logic [OUT_POS_W-1:0]  out_row,
  output logic [OUT_POS_W-1:0]  out_col,
  output logic                  out_frame_end,
  output logic                  out_run_end
);

  localparam int PB = PIXEL_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int FLW = $bits(cmd_flags_t);
  localparam int CMW = FLW + PB + CW + RW + CW;
  localparam int SLW = PB + RW + CW + 2;
  localparam int EW = 2 * SLW + 1;
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  // command queue between front and back
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_full;
  logic          cmd_empty;
  cmd_flags_t    f_flags;
  logic [PB-1:0] f_px;
  logic [CW-1:0] f_addr;
  logic [RW-1:0] f_row;
  logic [CW-1:0] f_col;
  cmd_flags_t    b_flags;
  logic [PB-1:0] b_px;
  logic [CW-1:0] b_addr;
  logic [RW-1:0] b_row;
  logic [CW-1:0] b_col;
  logic [CMW-1:0] cmd_dout;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  // result queue
  logic           res_push;
  logic           res_pop;
  logic           res_full;
  logic [EW-1:0]  res_din;
  logic [EW-1:0]  res_dout;
  logic [OCW-1:0] res_count;
  logic           sel_r;
  logic           head_two;
  logic [SLW-1:0] slot;
  logic [RW-1:0]  slot_row;
  logic [CW-1:0]  slot_col;

  mnf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .in_mode  (in_mode),
    .in_pixel (in_pixel),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_flags(f_flags),
    .cmd_px   (f_px),
    .cmd_addr (f_addr),
    .cmd_row  (f_row),
    .cmd_col  (f_col)
  );

  assign full = cmd_full;

  mnf_fifo #(
    .WIDTH(CMW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .din  ({f_flags, f_px, f_addr, f_row, f_col}),
    .pop  (cmd_pop),
    .dout (cmd_dout),
    .empty(cmd_empty),
    .full (cmd_full),
    .count(cmd_count)
  );

  assign {b_flags, b_px, b_addr, b_row, b_col} = cmd_dout;

  mnf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_flags(b_flags),
    .cmd_px   (b_px),
    .cmd_addr (b_addr),
    .cmd_row  (b_row),
    .cmd_col  (b_col),
    .cmd_pop  (cmd_pop),
    .out_count(res_count),
    .out_push (res_push),
    .out_entry(res_din)
  );

  mnf_fifo #(
    .WIDTH(EW),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_din),
    .pop  (res_pop),
    .dout (res_dout),
    .empty(empty),
    .full (res_full),
    .count(res_count)
  );

  // a queue word holds one or two results, sel_r picks the one on show
  assign head_two = res_dout[EW-1];
  assign slot     = sel_r ? res_dout[2*SLW-1:SLW] : res_dout[SLW-1:0];
  assign {out_filtered, slot_row, slot_col, out_frame_end, out_run_end} = slot;
  assign out_row  = OUT_POS_W'(slot_row);
  assign out_col  = OUT_POS_W'(slot_col);
  assign res_pop  = pop && !empty && (!head_two || sel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (pop && !empty) begin
      sel_r <= head_two && !sel_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("result queue written while full");

  assert property (@(posedge clk) disable iff (!rst_n) cmd_push |-> !cmd_full)
    else $error("command queue written while full");

  assert property (@(posedge clk) disable iff (!rst_n) sel_r |-> (!empty && head_two))
    else $error("second result selected on a single result word");

  assert property (@(posedge clk) disable iff (!rst_n)
                   cmd_count == '0 |-> !cmd_pop)
    else $error("command taken from an empty queue");

endmodule
